FILE: rtl/bapf_pkg.sv
// Shared types, codes, constants and color helpers of the blur automaton palette frame.
package bapf_pkg;

  localparam int unsigned MaxCols = 64;
  localparam int unsigned MaxRows = 64;

  localparam int unsigned SizeW = 7;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_COLS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS = 1'd1;

  typedef enum logic [1:0] {
    OP_REWIND  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  localparam logic [7:0] BorderVal = 8'd255;
  localparam logic [9:0] BorderColSum = 10'd765;

  // Exact tot/9 for tot below 2296: (tot * 3641) >> 15
  localparam logic [11:0] Div9Mul = 12'd3641;
  localparam int unsigned Div9Shift = 15;
  localparam logic [7:0] BlurBias = 8'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
  } in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       out_of_range;
  } out_t;

  // Entries packed as {red, green, blue}
  localparam logic [23:0] Palette [0:16] = '{
    24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'h000000,
    24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'h000000,
    24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF
  };

  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [3:0] f);
    logic [12:0] wa;
    logic [12:0] wb;
    logic [12:0] s;
    wa = 13'(a) * (13'd16 - 13'(f));
    wb = 13'(b) * 13'(f);
    s  = wa + wb;
    return s[11:4];
  endfunction

  function automatic out_t cell_color(logic [7:0] val);
    logic [23:0] ca;
    logic [23:0] cb;
    out_t        res;
    ca = Palette[{1'b0, val[7:4]}];
    cb = Palette[5'({1'b0, val[7:4]}) + 5'd1];
    res.red          = blend(ca[23:16], cb[23:16], val[3:0]);
    res.green        = blend(ca[15:8], cb[15:8], val[3:0]);
    res.blue         = blend(ca[7:0], cb[7:0], val[3:0]);
    res.out_of_range = 1'b0;
    return res;
  endfunction

endpackage

FILE: rtl/bapf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bapf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bapf_sweep.sv
// Raster sweep that computes one blur generation from the front buffer into the back buffer.
module bapf_sweep #(
  parameter int MAX_COLS = bapf_pkg::MaxCols,
  parameter int MAX_ROWS = bapf_pkg::MaxRows,
  localparam int Depth = MAX_COLS * MAX_ROWS,
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int XW    = $clog2(MAX_COLS + 1),
  localparam int YW    = $clog2(MAX_ROWS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] cols_i,
  input  logic [YW-1:0] rows_i,
  output logic          src_re_o,
  output logic [AW-1:0] src_addr_o,
  input  logic [7:0]    src_data_i,
  output logic          dst_we_o,
  output logic [AW-1:0] dst_addr_o,
  output logic [7:0]    dst_data_o,
  output logic          done_o
);

  localparam int LbAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Issue stage: x runs one column past the grid to flush the window and
  // keep line buffer read and write apart at each row turn.
  logic          busy_q, run_q;
  logic [XW-1:0] x0_q;
  logic [YW-1:0] y0_q;
  logic [AW-1:0] raddr_q;

  logic          v1_q;
  logic [XW-1:0] x1_q;
  logic [YW-1:0] y1_q;

  logic          v2_q;
  logic [XW-1:0] x2_q;
  logic [YW-1:0] y2_q;
  logic [9:0]    cs_a_q, cs_b_q, cs_c_q;
  logic [7:0]    ctr_a_q, ctr_b_q;

  logic          v3_q;
  logic          use3_q;
  logic [11:0]   tot_q;
  logic [7:0]    ctr3_q;
  logic [AW-1:0] waddr_q;

  logic          lb_re, lb_we;
  logic [15:0]   lb_rdata, lb_wdata;
  logic [7:0]    up2, up1;
  logic          col_ok, row0_ok, row1_ok, row2_ok;
  logic [7:0]    sv0, sv1, sv2;
  logic [9:0]    col_sum;
  logic [9:0]    left_sum;
  logic          out_here;
  logic [23:0]   prod;
  logic [7:0]    blur;

  assign src_re_o   = run_q && (x0_q < XW'(MAX_COLS)) && (y0_q < YW'(MAX_ROWS));
  assign src_addr_o = raddr_q;
  assign lb_re      = run_q && (x0_q < XW'(MAX_COLS));

  // Line buffer holds rows y-2 and y-1 of each column
  assign lb_we    = v1_q && (x1_q < XW'(MAX_COLS));
  assign up2      = lb_rdata[15:8];
  assign up1      = lb_rdata[7:0];
  assign lb_wdata = {up1, src_data_i};

  bapf_ram #(
    .Width(16),
    .Depth(MAX_COLS)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (lb_we),
    .waddr_i(x1_q[LbAW-1:0]),
    .wdata_i(lb_wdata),
    .re_i   (lb_re),
    .raddr_i(x0_q[LbAW-1:0]),
    .rdata_o(lb_rdata)
  );

  // Anything outside the interior in use reads as border
  always_comb begin
    col_ok  = x1_q < cols_i;
    row0_ok = y1_q < rows_i;
    row1_ok = (y1_q != '0) && ({2'b0, y1_q} <= {2'b0, rows_i});
    row2_ok = (y1_q > YW'(1)) && ({2'b0, y1_q} < ({2'b0, rows_i} + (YW+2)'(2)));
    sv0     = (col_ok && row0_ok) ? src_data_i : bapf_pkg::BorderVal;
    sv1     = (col_ok && row1_ok) ? up1 : bapf_pkg::BorderVal;
    sv2     = (col_ok && row2_ok) ? up2 : bapf_pkg::BorderVal;
    col_sum = 10'(sv0) + 10'(sv1) + 10'(sv2);
  end

  assign left_sum = (x2_q == XW'(1)) ? bapf_pkg::BorderColSum : cs_c_q;
  assign out_here = v2_q && (x2_q != '0) && (y2_q != '0);

  assign prod       = 24'(tot_q) * 24'(bapf_pkg::Div9Mul);
  assign blur       = prod[bapf_pkg::Div9Shift +: 8] + bapf_pkg::BlurBias;
  assign dst_we_o   = v3_q;
  assign dst_addr_o = waddr_q;
  assign dst_data_o = use3_q ? blur : ctr3_q;

  assign done_o = busy_q && !run_q && !v1_q && !v2_q && !v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      run_q   <= 1'b0;
      x0_q    <= '0;
      y0_q    <= '0;
      raddr_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      waddr_q <= '0;
    end else begin
      if (start_i) begin
        busy_q  <= 1'b1;
        run_q   <= 1'b1;
        x0_q    <= '0;
        y0_q    <= '0;
        raddr_q <= '0;
        waddr_q <= '0;
      end else begin
        if (done_o) begin
          busy_q <= 1'b0;
        end
        if (run_q) begin
          if (x0_q == XW'(MAX_COLS)) begin
            x0_q <= '0;
            if (y0_q == YW'(MAX_ROWS)) begin
              run_q <= 1'b0;
            end else begin
              y0_q <= y0_q + YW'(1);
            end
          end else begin
            x0_q <= x0_q + XW'(1);
          end
        end
        if (src_re_o) begin
          raddr_q <= raddr_q + AW'(1);
        end
        if (v3_q) begin
          waddr_q <= waddr_q + AW'(1);
        end
      end
      v1_q <= run_q;
      v2_q <= v1_q;
      v3_q <= out_here;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x0_q;
    y1_q <= y0_q;
    if (v1_q) begin
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      cs_a_q  <= col_sum;
      cs_b_q  <= cs_a_q;
      cs_c_q  <= cs_b_q;
      ctr_a_q <= up1;
      ctr_b_q <= ctr_a_q;
    end
    tot_q  <= 12'(cs_a_q) + 12'(cs_b_q) + 12'(left_sum);
    ctr3_q <= ctr_b_q;
    use3_q <= (x2_q <= cols_i) && (y2_q <= rows_i);
  end

endmodule

FILE: rtl/blur_automaton_palette_frame_top.sv
// Top level of the blur automaton palette frame: control, double-buffered grid, read-out.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (operation, cell_x/y)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (blue, green, red, oor)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Advance: one cell per cycle through the single read port of the front buffer.
// Read and unused operation code: the front buffer read lands in ST_DONE.
// After reset a clearing pass fills both buffers with 255; no item is taken
//   meanwhile, configuration writes are.
// One item at a time; a result waiting in the output register stalls only the next finish.
module blur_automaton_palette_frame_top #(
  parameter int MAX_COLS = bapf_pkg::MaxCols,
  parameter int MAX_ROWS = bapf_pkg::MaxRows
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bapf_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bapf_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bapf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bapf_pkg::SizeW-1:0]     cfg_data_i
);

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int XW    = $clog2(MAX_COLS + 1);
  localparam int YW    = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADV,
    ST_DONE
  } state_e;

  state_e                       state_q;
  logic [bapf_pkg::SizeW-1:0]   cols_q, rows_q;
  logic [AW-1:0]                clr_q;
  logic                         pend_q;
  logic                         front_q;
  logic [1:0]                   op_q;
  logic                         oor_q;
  logic                         out_valid_q;
  bapf_pkg::out_t               out_q;

  logic [XW-1:0]  cols_eff;
  logic [YW-1:0]  rows_eff;
  logic           accept;
  logic           in_oor;
  logic [AW-1:0]  rd_addr;
  logic           sw_start, sw_src_re, sw_dst_we, sw_done;
  logic [AW-1:0]  sw_src_addr, sw_dst_addr;
  logic [7:0]     sw_dst_data;
  logic [1:0]     ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata [2];
  logic [7:0]     front_data;
  bapf_pkg::out_t res;

  // Zero means one; above the grid saturates
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = XW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      cols_eff = XW'(MAX_COLS);
    end else begin
      cols_eff = XW'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = YW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_eff = YW'(MAX_ROWS);
    end else begin
      rows_eff = YW'(rows_q);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign in_oor      = (32'(in_data_i.cell_x) >= 32'(cols_eff)) ||
                       (32'(in_data_i.cell_y) >= 32'(rows_eff));
  assign rd_addr     = AW'(32'(in_data_i.cell_y) * MAX_COLS + 32'(in_data_i.cell_x));
  assign sw_start    = accept && (in_data_i.operation == bapf_pkg::OP_ADVANCE);

  bapf_sweep #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sw_start),
    .cols_i    (cols_eff),
    .rows_i    (rows_eff),
    .src_re_o  (sw_src_re),
    .src_addr_o(sw_src_addr),
    .src_data_i(front_data),
    .dst_we_o  (sw_dst_we),
    .dst_addr_o(sw_dst_addr),
    .dst_data_o(sw_dst_data),
    .done_o    (sw_done)
  );

  // Buffer 0 holds the grid when front_q is low, buffer 1 otherwise
  always_comb begin
    ram_we    = 2'b00;
    ram_re    = 2'b00;
    ram_waddr = (state_q == ST_CLEAR) ? clr_q : sw_dst_addr;
    ram_wdata = (state_q == ST_CLEAR) ? bapf_pkg::BorderVal : sw_dst_data;
    ram_raddr = (state_q == ST_ADV) ? sw_src_addr : rd_addr;
    if (state_q == ST_CLEAR) begin
      ram_we = 2'b11;
    end else if (state_q == ST_ADV) begin
      if (sw_dst_we) begin
        ram_we = front_q ? 2'b01 : 2'b10;
      end
      if (sw_src_re) begin
        ram_re = front_q ? 2'b10 : 2'b01;
      end
    end else if (accept && (in_data_i.operation == bapf_pkg::OP_READ) && !in_oor) begin
      ram_re = front_q ? 2'b10 : 2'b01;
    end
  end

  bapf_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_grid0 (
    .clk_i  (clk_i),
    .we_i   (ram_we[0]),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re[0]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata[0])
  );

  bapf_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_grid1 (
    .clk_i  (clk_i),
    .we_i   (ram_we[1]),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re[1]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata[1])
  );

  assign front_data = front_q ? ram_rdata[1] : ram_rdata[0];

  always_comb begin
    res = '0;
    if (op_q == bapf_pkg::OP_READ) begin
      if (oor_q) begin
        res.out_of_range = 1'b1;
      end else begin
        res = bapf_pkg::cell_color(front_data);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cols_q      <= bapf_pkg::SizeW'(MAX_COLS > 127 ? 127 : MAX_COLS);
      rows_q      <= bapf_pkg::SizeW'(MAX_ROWS > 127 ? 127 : MAX_ROWS);
      clr_q       <= '0;
      pend_q      <= 1'b0;
      front_q     <= 1'b0;
      op_q        <= '0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bapf_pkg::CFG_COLS: cols_q <= cfg_data_i;
          bapf_pkg::CFG_ROWS: rows_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(Depth - 1)) begin
            front_q <= 1'b0;
            state_q <= pend_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_q   <= in_data_i.operation;
            oor_q  <= in_oor;
            pend_q <= 1'b1;
            unique case (in_data_i.operation)
              bapf_pkg::OP_REWIND: begin
                clr_q   <= '0;
                state_q <= ST_CLEAR;
              end
              bapf_pkg::OP_ADVANCE: state_q <= ST_ADV;
              default:              state_q <= ST_DONE;
            endcase
          end
        end
        ST_ADV: begin
          if (sw_done) begin
            front_q <= !front_q;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold the finished item until the output register frees up
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (ram_we == 2'b00))
    else $error("grid written while idle");

  a_done_in_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_done |-> (state_q == ST_ADV))
    else $error("sweep finished outside an advance");

  a_buf_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV) |-> ((ram_we & ram_re) == 2'b00))
    else $error("same buffer read and written during an advance");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item taken before the first finished");

  a_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV && sw_done) |=> (front_q != $past(front_q)))
    else $error("front buffer not swapped after an advance");

endmodule
